// ===== src/cbm_pkg.sv =====
// Shared types, codes and constants of the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

   // Store geometry.
   localparam int ROM_BANKS      = 32;
   localparam int ROM_BANK_BYTES = 16384;
   localparam int RAM_BANKS      = 4;
   localparam int RAM_BANK_BYTES = 8192;
   localparam int ROM_BYTES      = ROM_BANKS * ROM_BANK_BYTES;
   localparam int RAM_BYTES      = RAM_BANKS * RAM_BANK_BYTES;
   localparam int ROM_ADDR_W     = $clog2(ROM_BYTES);
   localparam int RAM_ADDR_W     = $clog2(RAM_BYTES);
   localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

   // Bank select widths follow the bus write masks.
   localparam int ROM_SEL_W = 5;
   localparam int RAM_SEL_W = 2;

   // Configuration register widths and indexes.
   localparam int ROM_COUNT_W = 10;
   localparam int RAM_COUNT_W = 5;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BANK_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BANK_COUNT = 1'b1;

   // Request codes.
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_LOAD  = 2'd2;

   // Bus regions by the top three address bits.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'b000;
   localparam logic [2:0] REGION_ROM_SELECT = 3'b001;
   localparam logic [2:0] REGION_RAM_SELECT = 3'b010;
   localparam logic [2:0] REGION_SAVE_RAM   = 3'b101;

   // Value written below 0x2000 that enables save RAM.
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] bus_address;
      logic [18:0] image_offset;
      logic [7:0]  write_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       access_error;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== src/cbm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module cbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: banked ROM image and save RAM behind a CPU bus port.
//
// Input channel: an item (req_item) is taken at a rising edge where start is
// high and busy is low. An item is a bus read, a bus write or a load of one
// byte into the ROM image.
// Result channel: every item gives one result on rsp_item, marked by rsp_valid
// for exactly one cycle, in the cycle after the item was taken. The receiver
// cannot stall; the result is gone after that cycle.
// Throughput is one item per cycle while busy is low; the result comes from the
// registered read of the ROM and save RAM memories. A read always sees the
// effect of the item taken just before it.
// Configuration: csr_we writes csr_wdata into the register chosen by
// csr_index (0 ROM bank count, 1 save RAM bank count) at the rising edge.
// Reset (synchronous, active high) clears the bank selects, RAM enable and
// counts to their defaults and drops rsp_valid; busy is high during reset and
// in the cycle after it. The memory contents are not cleared; they are defined
// once loaded or written.
`default_nettype none

module cartridge_bank_mapper (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire cbm_pkg::req_item_type              req_item,
   output logic                                    rsp_valid,
   output cbm_pkg::rsp_item_type                   rsp_item,
   input  wire logic                               csr_we,
   input  wire logic [cbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [cbm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ROM_LIMIT_W = $clog2(cbm_pkg::ROM_BANKS + 1);
   localparam int RAM_LIMIT_W = $clog2(cbm_pkg::RAM_BANKS + 1);

   // Control state.
   logic                              busy_ff;
   logic [cbm_pkg::ROM_COUNT_W-1:0]   rom_count_ff, rom_count_in;
   logic [cbm_pkg::RAM_COUNT_W-1:0]   ram_count_ff, ram_count_in;
   logic                              ram_en_ff, ram_en_in;
   logic [cbm_pkg::ROM_SEL_W-1:0]     rom_sel_ff, rom_sel_in;
   logic [cbm_pkg::RAM_SEL_W-1:0]     ram_sel_ff, ram_sel_in;
   logic                              rsp_valid_ff;
   logic                              src_rom_ff, src_rom_in;
   logic                              src_ram_ff, src_ram_in;
   logic                              err_ff, err_in;

   logic                              accept;
   logic                              is_read, is_write, is_load;
   logic [2:0]                        region;
   logic                              rom_region, ram_region, ram_on;
   logic [ROM_LIMIT_W-1:0]            rom_limit;
   logic [RAM_LIMIT_W-1:0]            ram_limit;
   logic [cbm_pkg::ROM_SEL_W-1:0]     rom_pick;
   logic [cbm_pkg::RAM_SEL_W-1:0]     ram_pick;
   logic [ROM_LIMIT_W-1:0]            rom_top;
   logic [RAM_LIMIT_W-1:0]            ram_top;

   logic                              rom_we, ram_we;
   logic [cbm_pkg::ROM_ADDR_W-1:0]    rom_addr;
   logic [cbm_pkg::RAM_ADDR_W-1:0]    ram_addr;
   logic [7:0]                        rom_q, ram_q;

   // Request decode.
   assign accept     = start && !busy_ff;
   assign is_read    = req_item.req_type == cbm_pkg::REQ_READ;
   assign is_write   = req_item.req_type == cbm_pkg::REQ_WRITE;
   assign is_load    = req_item.req_type == cbm_pkg::REQ_LOAD;
   assign region     = req_item.bus_address[15:13];
   assign rom_region = !req_item.bus_address[15];
   assign ram_region = region == cbm_pkg::REGION_SAVE_RAM;
   assign ram_on     = ram_en_ff && (ram_count_ff != '0);

   // Effective bank counts used for clamping.
   always_comb begin
      if (rom_count_ff < cbm_pkg::ROM_COUNT_W'(2)) begin
         rom_limit = ROM_LIMIT_W'(2);
      end else if (rom_count_ff > cbm_pkg::ROM_COUNT_W'(cbm_pkg::ROM_BANKS)) begin
         rom_limit = ROM_LIMIT_W'(cbm_pkg::ROM_BANKS);
      end else begin
         rom_limit = rom_count_ff[ROM_LIMIT_W-1:0];
      end
      if (ram_count_ff > cbm_pkg::RAM_COUNT_W'(cbm_pkg::RAM_BANKS)) begin
         ram_limit = RAM_LIMIT_W'(cbm_pkg::RAM_BANKS);
      end else begin
         ram_limit = ram_count_ff[RAM_LIMIT_W-1:0];
      end
   end

   // Clamped bank numbers from the written byte.
   always_comb begin
      rom_top  = rom_limit - ROM_LIMIT_W'(1);
      ram_top  = ram_limit - RAM_LIMIT_W'(1);
      rom_pick = req_item.write_data[cbm_pkg::ROM_SEL_W-1:0];
      if (rom_pick == '0) begin
         rom_pick = cbm_pkg::ROM_SEL_W'(1);
      end
      if (ROM_LIMIT_W'(rom_pick) >= rom_limit) begin
         rom_pick = rom_top[cbm_pkg::ROM_SEL_W-1:0];
      end
      ram_pick = req_item.write_data[cbm_pkg::RAM_SEL_W-1:0];
      if (ram_limit == '0) begin
         ram_pick = '0;
      end else if (RAM_LIMIT_W'(ram_pick) >= ram_limit) begin
         ram_pick = ram_top[cbm_pkg::RAM_SEL_W-1:0];
      end
   end

   // Mapper register updates from bus writes and configuration writes.
   always_comb begin
      rom_count_in = rom_count_ff;
      ram_count_in = ram_count_ff;
      ram_en_in    = ram_en_ff;
      rom_sel_in   = rom_sel_ff;
      ram_sel_in   = ram_sel_ff;
      if (csr_we) begin
         case (csr_index)
            cbm_pkg::CSR_ROM_BANK_COUNT: begin
               rom_count_in = csr_wdata[cbm_pkg::ROM_COUNT_W-1:0];
            end
            cbm_pkg::CSR_RAM_BANK_COUNT: begin
               ram_count_in = csr_wdata[cbm_pkg::RAM_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
      if (accept && is_write) begin
         case (region)
            cbm_pkg::REGION_RAM_ENABLE: begin
               ram_en_in = req_item.write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY;
            end
            cbm_pkg::REGION_ROM_SELECT: begin
               rom_sel_in = rom_pick;
            end
            cbm_pkg::REGION_RAM_SELECT: begin
               ram_sel_in = ram_pick;
            end
            default: begin
            end
         endcase
      end
   end

   // Memory ports: loads and reads share the ROM port.
   always_comb begin
      rom_we = accept && is_load &&
               ({1'b0, req_item.image_offset} < 20'(cbm_pkg::ROM_BYTES));
      if (is_load) begin
         rom_addr = cbm_pkg::ROM_ADDR_W'(req_item.image_offset);
      end else if (req_item.bus_address[14]) begin
         rom_addr = cbm_pkg::ROM_ADDR_W'({rom_sel_ff,
                       req_item.bus_address[cbm_pkg::ROM_OFS_W-1:0]});
      end else begin
         rom_addr = cbm_pkg::ROM_ADDR_W'(req_item.bus_address[cbm_pkg::ROM_OFS_W-1:0]);
      end
      ram_we   = accept && is_write && ram_region && ram_on;
      ram_addr = cbm_pkg::RAM_ADDR_W'({ram_sel_ff,
                    req_item.bus_address[cbm_pkg::RAM_OFS_W-1:0]});
   end

   // Source of the result byte, resolved at acceptance.
   assign src_rom_in = is_read && rom_region;
   assign src_ram_in = is_read && ram_region && ram_on;
   assign err_in     = is_read && !rom_region && !ram_region;

   // Control registers and the result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rom_count_ff <= cbm_pkg::ROM_COUNT_W'(2);
         ram_count_ff <= '0;
         ram_en_ff    <= 1'b0;
         rom_sel_ff   <= cbm_pkg::ROM_SEL_W'(1);
         ram_sel_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         src_rom_ff   <= 1'b0;
         src_ram_ff   <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rom_count_ff <= rom_count_in;
         ram_count_ff <= ram_count_in;
         ram_en_ff    <= ram_en_in;
         rom_sel_ff   <= rom_sel_in;
         ram_sel_ff   <= ram_sel_in;
         rsp_valid_ff <= accept;
         src_rom_ff   <= accept && src_rom_in;
         src_ram_ff   <= accept && src_ram_in;
         err_ff       <= accept && err_in;
      end
   end

   cbm_ram #(
      .WIDTH (8),
      .DEPTH (cbm_pkg::ROM_BYTES)
   ) u_rom (
      .clock (clock),
      .we    (rom_we),
      .addr  (rom_addr),
      .wdata (req_item.write_data),
      .rdata (rom_q)
   );

   cbm_ram #(
      .WIDTH (8),
      .DEPTH (cbm_pkg::RAM_BYTES)
   ) u_save_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_item.write_data),
      .rdata (ram_q)
   );

   // Result item: the registered memory data, chosen by the stored source.
   always_comb begin
      if (src_rom_ff) begin
         rsp_item.read_data = rom_q;
      end else if (src_ram_ff) begin
         rsp_item.read_data = ram_q;
      end else begin
         rsp_item.read_data = '0;
      end
      rsp_item.access_error = err_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = busy_ff;

endmodule

`default_nettype wire

// ===== src/cbm_checker.sv =====
// Port-level assertions for the cartridge bank mapper, bound to its top level.
`default_nettype none

module cbm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire cbm_pkg::req_item_type           req_item,
   input wire logic                            rsp_valid,
   input wire cbm_pkg::rsp_item_type           rsp_item
);

   logic accept;
   logic bad_read;

   assign accept   = start && !busy;
   assign bad_read = accept && (req_item.req_type == cbm_pkg::REQ_READ) &&
                     (req_item.bus_address[15:14] == 2'b11 ||
                      req_item.bus_address[15:13] == 3'b100);

   // Every accepted item gives its result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("no result after an accepted item");

   // No result appears without an item taken the cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result without an accepted item");

   // A read outside both the ROM and save RAM windows flags an error.
   a_unmapped_read: assert property (@(posedge clock) disable iff (reset)
      bad_read |=> rsp_item.access_error && rsp_item.read_data == 8'h00)
      else $error("unmapped read not flagged");

   // Writes and loads return an empty result.
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.req_type != cbm_pkg::REQ_READ |=>
         !rsp_item.access_error && rsp_item.read_data == 8'h00)
      else $error("non-read item returned data or an error");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
